// File: sv/mhpq_pkg.sv
// ============================================================================
// mhpq_pkg
// Shared types and constants for the min-heap priority queue.
// ============================================================================
package mhpq_pkg;

    localparam int OUT_VAL_W = 32;   // width of value result ports
    localparam int OUT_CNT_W = 9;    // width of count result port

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_LOAD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_PLACE,
        S_DONE
    } t_state;

    // Datapath operation issued by the controller each cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,     // latch request, update count, open the hole on a push
        DP_RD_LAST,    // read last entry
        DP_LOAD_LAST,  // last entry becomes the sinking item
        DP_UP_RD,      // read parent of hole
        DP_UP_MOVE,    // parent moves down into hole
        DP_DN_RD,      // read both children of hole
        DP_DN_MOVE,    // smaller child moves up into hole
        DP_PLACE       // write the item into the hole
    } t_dp_op;

    typedef struct packed {
        logic full;      // count == capacity
        logic empty;     // count == 0
        logic up_swap;   // item < parent
        logic up_last;   // parent is the root
        logic dn_swap;   // a child exists and the smaller one < item
    } t_dp_stat;

endpackage

// File: sv/mhpq_datapath.sv
// ============================================================================
// mhpq_datapath
// Heap store, hole position, item register, count and result registers.
// ============================================================================
module mhpq_datapath
    import mhpq_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_op               i_op,
    input  logic                 i_req_type,
    input  logic [31:0]          i_push_value,
    output t_dp_stat             o_stat,
    output logic [OUT_VAL_W-1:0] o_popped_value,
    output logic [OUT_VAL_W-1:0] o_top_value,
    output logic [OUT_CNT_W-1:0] o_entry_count_out,
    output logic                 o_is_empty,
    output t_status              o_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = CW + 1;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_pos,   n_pos;
    logic [DATA_WIDTH-1:0] r_cur,   n_cur;
    logic [DATA_WIDTH-1:0] r_popped, n_popped;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_root;
    logic [DATA_WIDTH-1:0] r_rd_a, r_rd_b;

    logic [AW-1:0]         rd_addr_a, rd_addr_b;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [AW-1:0]         parent;
    logic [KW-1:0]         kid_a, kid_b;
    logic                  kid_a_ok, kid_b_ok, pick_b;
    logic [DATA_WIDTH-1:0] child;
    logic [AW-1:0]         child_pos;

    // Tree navigation
    assign parent   = AW'((r_pos - AW'(1)) >> 1);
    assign kid_a    = KW'({r_pos, 1'b1});
    assign kid_b    = kid_a + KW'(1);
    assign kid_a_ok = kid_a < KW'(r_count);
    assign kid_b_ok = kid_b < KW'(r_count);
    assign pick_b   = kid_b_ok && ($signed(r_rd_b) < $signed(r_rd_a));
    assign child    = pick_b ? r_rd_b : r_rd_a;
    assign child_pos = pick_b ? kid_b[AW-1:0] : kid_a[AW-1:0];

    always_comb begin
        o_stat.full    = r_count == CW'(CAPACITY);
        o_stat.empty   = r_count == '0;
        o_stat.up_swap = $signed(r_cur) < $signed(r_rd_a);
        o_stat.up_last = parent == '0;
        o_stat.dn_swap = kid_a_ok && ($signed(child) < $signed(r_cur));
    end

    // Next-state of the datapath registers and memory port control
    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_popped  = r_popped;
        n_status  = r_status;
        rd_addr_a = parent;
        rd_addr_b = kid_b[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_cur;
        unique case (i_op)
            DP_ACCEPT: begin
                n_popped = '0;
                n_status = ST_OK;
                if (i_req_type) begin
                    if (o_stat.empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped = r_root;
                        n_count  = r_count - CW'(1);
                    end
                end else begin
                    if (o_stat.full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_cur   = DATA_WIDTH'($signed(i_push_value));
                        n_pos   = r_count[AW-1:0];
                        n_count = r_count + CW'(1);
                    end
                end
            end
            DP_RD_LAST: begin
                rd_addr_a = r_count[AW-1:0];
            end
            DP_LOAD_LAST: begin
                n_cur = r_rd_a;
                n_pos = '0;
            end
            DP_UP_RD: begin
                rd_addr_a = parent;
            end
            DP_UP_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rd_a;
                n_pos   = parent;
            end
            DP_DN_RD: begin
                rd_addr_a = kid_a[AW-1:0];
                rd_addr_b = kid_b[AW-1:0];
            end
            DP_DN_MOVE: begin
                wr_en   = 1'b1;
                wr_data = child;
                n_pos   = child_pos;
            end
            DP_PLACE: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_popped <= n_popped;
    end

    // Heap store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    // Copy of slot 0, kept for pops and the top result
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == '0) begin
            r_root <= wr_data;
        end
    end

    assign o_popped_value    = OUT_VAL_W'($signed(r_popped));
    assign o_top_value       = (r_count != '0) ? OUT_VAL_W'($signed(r_root)) : '0;
    assign o_entry_count_out = OUT_CNT_W'(r_count);
    assign o_is_empty        = r_count == '0;
    assign o_status          = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_up_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == DP_UP_MOVE |-> r_pos != '0)
        else $error("sift up moved at the root");

    a_dn_kid_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == DP_DN_MOVE |-> kid_a_ok)
        else $error("sift down used a child past the count");

endmodule

// File: sv/mhpq_ctrl.sv
// ============================================================================
// mhpq_ctrl
// Push / pop sequencer: sift up / sift down, read then compare per level.
// ============================================================================
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_req_type,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy,
    output logic     o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type) begin
                        n_state = i_stat.empty ? S_DONE : S_POP_RD;
                    end else if (i_stat.full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = i_stat.empty ? S_PLACE : S_UP_RD;
                    end
                end
            end
            S_POP_RD:   n_state = S_POP_LOAD;
            S_POP_LOAD: n_state = i_stat.empty ? S_DONE : S_DN_RD;
            S_UP_RD:    n_state = S_UP_CMP;
            S_UP_CMP: begin
                if (i_stat.up_swap) begin
                    n_state = i_stat.up_last ? S_PLACE : S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_RD:    n_state = S_DN_CMP;
            S_DN_CMP:   n_state = i_stat.dn_swap ? S_DN_RD : S_DONE;
            S_PLACE:    n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op   = DP_NOP;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                o_op   = i_start ? DP_ACCEPT : DP_NOP;
            end
            S_POP_RD:   o_op = DP_RD_LAST;
            S_POP_LOAD: o_op = DP_LOAD_LAST;
            S_UP_RD:    o_op = DP_UP_RD;
            S_UP_CMP:   o_op = i_stat.up_swap ? DP_UP_MOVE : DP_PLACE;
            S_DN_RD:    o_op = DP_DN_RD;
            S_DN_CMP:   o_op = i_stat.dn_swap ? DP_DN_MOVE : DP_PLACE;
            S_PLACE:    o_op = DP_PLACE;
            S_DONE:     o_done = 1'b1;
            default:    o_op = DP_NOP;
        endcase
    end

endmodule

// File: sv/min_heap_priority_queue.sv
// ============================================================================
// min_heap_priority_queue
// Binary min-heap priority queue with fixed capacity; push / pop requests.
// ============================================================================
//
//  channel   | handshake                  | fields
//  ----------+----------------------------+-----------------------------------
//  request   | start in, busy out         | i_req_type, i_push_value
//  result    | o_done out (1-cycle pulse) | o_popped_value, o_top_value,
//            |                            | o_entry_count_out, o_is_empty,
//            |                            | o_status
//
//  An item is taken when start is high and busy is low; exactly one result
//  item follows, shown for the single cycle o_done is high.
//  A sift moves at most floor(log2(CAPACITY)) levels; each level takes one
//  registered read of the heap store and one compare-and-move step.
//  Synchronous active-low reset empties the queue; the store is not cleared.
//  Results cannot be stalled: busy stays high until the o_done cycle ends.
//
//  Sifting uses a hole: the moving item sits in a register while the
//  parent (or smaller child) is copied into the hole, and is written once
//  at its final place. A copy of slot 0 gives the minimum without a read.
// ============================================================================
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [31:0] i_push_value,
    output logic        o_done,
    output logic [31:0] o_popped_value,
    output logic [31:0] o_top_value,
    output logic [8:0]  o_entry_count_out,
    output logic        o_is_empty,
    output logic [1:0]  o_status
);

    t_dp_op   dp_op;
    t_dp_stat dp_stat;
    t_status  status;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (dp_stat),
        .o_op       (dp_op),
        .o_busy     (busy),
        .o_done     (o_done)
    );

    mhpq_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (dp_op),
        .i_req_type        (i_req_type),
        .i_push_value      (i_push_value),
        .o_stat            (dp_stat),
        .o_popped_value    (o_popped_value),
        .o_top_value       (o_top_value),
        .o_entry_count_out (o_entry_count_out),
        .o_is_empty        (o_is_empty),
        .o_status          (status)
    );

    assign o_status = status;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("result strobe not followed by idle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && status != ST_OK |-> o_popped_value == '0)
        else $error("failed request reports a popped value");

endmodule

// File: dv/min_heap_priority_queue_tb.sv
// ============================================================================
// min_heap_priority_queue_tb
// Self-checking bench for the min-heap queue: a shadow heap predicts each
// result from every accepted request, and each o_done result is compared
// field by field. Stimulus runs a short directed set, then random requests
// that fill the store to capacity, then a pop-heavy mix.
// ============================================================================
module min_heap_priority_queue_tb;
    import mhpq_pkg::*;

    localparam int   HEAP_DEPTH     = 256;
    localparam int   RANDOM_ITEMS   = 450;
    localparam int   WATCHDOG_LIMIT = 500;  // worst case is an idle gap plus one busy sift
    localparam int   TAIL_CYCLES    = 40;   // quiet time after the last result
    localparam logic REQ_PUSH       = 1'b0;
    localparam logic REQ_POP        = 1'b1;

    // One predicted result item
    typedef struct {
        logic [31:0] popped;
        logic [31:0] top;
        logic [8:0]  count;
        logic        empty;
        t_status     status;
    } t_heap_result;

    // Shadow heap: sifts each accepted request and queues the result it owes
    class heap_tracker;
        int           slots[HEAP_DEPTH];
        int           fill;
        int           max_fill;
        int           errors;
        int           n_push;
        int           n_pop;
        int           n_full;
        int           n_empty;
        t_heap_result awaited_results[$];

        function void take_request(logic pop, logic [31:0] value);
            int           pos;
            int           kid;
            int           up;
            int           tmp;
            t_heap_result res;
            res.popped = '0;
            res.status = ST_OK;
            if (pop == REQ_PUSH) begin
                n_push++;
                if (fill >= HEAP_DEPTH) begin
                    res.status = ST_FULL;
                    n_full++;
                end else begin
                    slots[fill] = value;
                    pos = fill;
                    fill++;
                    // climb while strictly smaller than the parent
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (slots[pos] >= slots[up]) break;
                        tmp = slots[pos];
                        slots[pos] = slots[up];
                        slots[up] = tmp;
                        pos = up;
                    end
                end
            end else begin
                n_pop++;
                if (fill == 0) begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    res.popped = slots[0];
                    slots[0] = slots[fill - 1];
                    fill--;
                    pos = 0;
                    // sink toward the smaller child, left child wins a tie
                    while (pos < fill) begin
                        kid = 2 * pos + 1;
                        if (kid >= fill) break;
                        if (kid + 1 < fill && slots[kid + 1] < slots[kid]) kid++;
                        if (slots[kid] >= slots[pos]) break;
                        tmp = slots[pos];
                        slots[pos] = slots[kid];
                        slots[kid] = tmp;
                        pos = kid;
                    end
                end
            end
            res.top   = (fill > 0) ? slots[0] : 0;
            res.count = 9'(fill);
            res.empty = (fill == 0);
            if (fill > max_fill) max_fill = fill;
            awaited_results.push_back(res);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] popped, logic [31:0] top,
                                   logic [8:0] count, logic empty, logic [1:0] status);
            t_heap_result want;
            if (awaited_results.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("popped_value",    want.popped, popped);
            compare_field("top_value",       want.top,    top);
            compare_field("entry_count_out", 32'(want.count), 32'(count));
            compare_field("is_empty",        32'(want.empty), 32'(empty));
            compare_field("status",          32'(want.status), 32'(status));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [31:0] i_push_value;
    logic        o_done;
    logic [31:0] o_popped_value;
    logic [31:0] o_top_value;
    logic [8:0]  o_entry_count_out;
    logic        o_is_empty;
    logic [1:0]  o_status;

    heap_tracker tracker;
    int          stall_cycles = 0;
    int          n_random     = 0;
    bit          idle_off     = 1'b0;

    min_heap_priority_queue #(
        .CAPACITY   (HEAP_DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_push_value      (i_push_value),
        .o_done            (o_done),
        .o_popped_value    (o_popped_value),
        .o_top_value       (o_top_value),
        .o_entry_count_out (o_entry_count_out),
        .o_is_empty        (o_is_empty),
        .o_status          (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: o_done is a one-cycle strobe, sampled at the edge ending it
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            tracker.check_result(o_popped_value, o_top_value, o_entry_count_out,
                                 o_is_empty, o_status);
        end
    end

    // Cycles since the last handshake on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Often tiny values so ties and equal keys are common, plus the extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 16) - 8;
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until the edge that takes it. start stays
    // high afterward, so a back-to-back item needs only new field values.
    task automatic issue_request(logic pop, logic [31:0] value);
        // a quarter of the time, start drops for a random idle gap first
        if (!idle_off && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= pop;
        i_push_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.take_request(pop, value);
    endtask

    task automatic random_request(int pop_pct);
        issue_request(($urandom_range(99) < pop_pct) ? REQ_POP : REQ_PUSH, pick_value());
        n_random++;
    endtask

    initial begin
        tracker      = new;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = REQ_PUSH;
        i_push_value = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pop, value extremes, ties, drain to empty and
        // pop again, a lone entry, alternating bit patterns
        issue_request(REQ_POP,  $urandom);
        issue_request(REQ_PUSH, 32'h0000_0000);
        issue_request(REQ_PUSH, 32'h7FFF_FFFF);
        issue_request(REQ_PUSH, 32'h8000_0000);
        issue_request(REQ_PUSH, 32'hFFFF_FFFF);
        issue_request(REQ_PUSH, 32'd5);
        issue_request(REQ_PUSH, 32'd5);
        issue_request(REQ_PUSH, 32'd3);
        issue_request(REQ_PUSH, 32'd5);
        repeat (8) issue_request(REQ_POP, $urandom);
        issue_request(REQ_POP,  32'hFFFF_FFFF);
        issue_request(REQ_PUSH, 32'h7FFF_FFFF);
        issue_request(REQ_POP,  32'h0000_0000);
        issue_request(REQ_PUSH, 32'hAAAA_AAAA);
        issue_request(REQ_PUSH, 32'h5555_5555);
        issue_request(REQ_POP,  $urandom);
        issue_request(REQ_POP,  $urandom);

        // Random, shallow heap: frequent empty pops
        repeat (60) random_request(45);

        // Fill to capacity; the first stretch runs with start never dropped
        idle_off = 1'b1;
        while (tracker.fill < HEAP_DEPTH) begin
            random_request(4);
            if (n_random > 180) idle_off = 1'b0;
        end
        idle_off = 1'b0;
        repeat (3) random_request(0);   // all dropped, store is full
        repeat (4) random_request(25);

        // Pop-heavy mix through the deep levels of the tree
        while (n_random < RANDOM_ITEMS) random_request(65);

        start <= 1'b0;
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d pushes (%0d dropped while full), %0d pops (%0d on empty).",
                 tracker.n_push + tracker.n_pop, tracker.n_push, tracker.n_full,
                 tracker.n_pop, tracker.n_empty);
        $display("Deepest fill %0d of %0d entries, %0d mismatches.",
                 tracker.max_fill, HEAP_DEPTH, tracker.errors);
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
